/* rtl/grouped_query_attention_decode_macros.svh */
// Assertion macros shared by the checkers of the attention decode block.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef GROUPED_QUERY_ATTENTION_DECODE_MACROS_SVH
`define GROUPED_QUERY_ATTENTION_DECODE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GQAD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gqad assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define GQAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gqad assertion failed");

`endif

/* rtl/gqad_pkg.sv */
// Shared constants, types and lookup tables of the attention decode block.
// No dependencies; the files that use it refer to it by scoped names.
package gqad_pkg;

    // Block geometry
    localparam int NUM_Q_HEADS   = 15;
    localparam int NUM_KV_HEADS  = 5;
    localparam int HEAD_DIM      = 64;
    localparam int CONTEXT_SLOTS = 1024;
    localparam int VALUE_BITS    = 16;
    localparam int Q_PER_KV      = (NUM_Q_HEADS / NUM_KV_HEADS > 0) ?
                                   (NUM_Q_HEADS / NUM_KV_HEADS) : 1;

    // Field widths
    localparam int REQ_W  = 2;
    localparam int POS_W  = 20;
    localparam int HEAD_W = 4;
    localparam int CH_W   = 6;
    localparam int VAL_W  = VALUE_BITS;

    // Stream packing
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = REQ_W;
    localparam int OUT_TDATA_W = 24;
    localparam int POS_LSB     = 0;
    localparam int HEAD_LSB    = POS_LSB + POS_W;
    localparam int CH_LSB      = HEAD_LSB + HEAD_W;
    localparam int VAL_LSB     = CH_LSB + CH_W;
    localparam int OUT_VAL_LSB = CH_W;
    localparam int OUT_PAD_W   = OUT_TDATA_W - CH_W - VAL_W;

    // Storage geometry
    localparam int SLOT_W   = $clog2(CONTEXT_SLOTS);
    localparam int KV_W     = $clog2(NUM_KV_HEADS);
    localparam int ROW_W    = $clog2(CONTEXT_SLOTS * NUM_KV_HEADS);
    localparam int KC_DEPTH = CONTEXT_SLOTS * NUM_KV_HEADS * HEAD_DIM;
    localparam int QS_DEPTH = NUM_Q_HEADS * HEAD_DIM;

    // Arithmetic widths
    localparam int SCORE_W    = 32;
    localparam int PROB_W     = 17;
    localparam int SUM_W      = 27;
    localparam int NUM_W      = 33;
    localparam int DIV_CNT_W  = $clog2(NUM_W);
    localparam int ACC_W      = 40;
    localparam int MUL_A_W    = 18;
    localparam int PROD_W     = MUL_A_W + VAL_W;
    localparam int EXP_PROD_W = 34;
    localparam int LIN_W      = 24;
    localparam int OUT_R_W    = ACC_W - 16;

    // Front queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [CH_W-1:0] LAST_CH = CH_W'(HEAD_DIM - 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_KEY   = 2'd0,
        REQ_VALUE = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_RUN   = 2'd3
    } req_t;

    typedef struct packed {
        req_t                    kind;
        logic [POS_W-1:0]        position;
        logic [HEAD_W-1:0]       head;
        logic [KV_W-1:0]         kv_head;
        logic [CH_W-1:0]         channel;
        logic signed [VAL_W-1:0] value;
    } item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SC_ISSUE,
        ST_SC_DRAIN,
        ST_SC_DONE,
        ST_WT_READ,
        ST_WT_DATA,
        ST_WT_MUL,
        ST_WT_WRITE,
        ST_NM_READ,
        ST_NM_START,
        ST_NM_WAIT,
        ST_AC_ISSUE,
        ST_AC_DRAIN,
        ST_AC_EMIT
    } eng_state_t;

    // exp(-f) samples at sixteenths of one, Q1.16
    function automatic logic [PROB_W-1:0] frac_lut(input logic [4:0] k);
        logic [PROB_W-1:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd61565;
            5'd2:    v = 17'd57835;
            5'd3:    v = 17'd54331;
            5'd4:    v = 17'd51039;
            5'd5:    v = 17'd47947;
            5'd6:    v = 17'd45042;
            5'd7:    v = 17'd42313;
            5'd8:    v = 17'd39750;
            5'd9:    v = 17'd37341;
            5'd10:   v = 17'd35079;
            5'd11:   v = 17'd32954;
            5'd12:   v = 17'd30957;
            5'd13:   v = 17'd29081;
            5'd14:   v = 17'd27319;
            5'd15:   v = 17'd25664;
            default: v = 17'd24109;
        endcase
        return v;
    endfunction

    // exp(-n) for integer n, Q1.16
    function automatic logic [PROB_W-1:0] intp_lut(input logic [3:0] n);
        logic [PROB_W-1:0] v;
        case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/gqad_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gqad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/gqad_front.sv */
// Front end: accepts stream requests, drops out-of-range ones, maps query
// heads to key/value heads and queues the rest. Depends on gqad_pkg.
module gqad_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gqad_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [gqad_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output gqad_pkg::item_t                    item,
    output logic                               item_valid,
    input  logic                               item_pop
);

    gqad_pkg::item_t                     fifo_reg [gqad_pkg::QDEPTH];
    logic [gqad_pkg::QPTR_W-1:0]         wr_ptr_reg;
    logic [gqad_pkg::QPTR_W-1:0]         rd_ptr_reg;
    logic [gqad_pkg::QPTR_W:0]           cnt_reg;
    logic [gqad_pkg::QPTR_W:0]           cnt_next;
    gqad_pkg::item_t                     in_item;
    logic                                keep;
    logic                                push;

    // Unpack and classify the incoming request
    always_comb
    begin
        in_item.kind     = gqad_pkg::req_t'(s_axis_tuser);
        in_item.position = s_axis_tdata[gqad_pkg::POS_LSB +: gqad_pkg::POS_W];
        in_item.head     = s_axis_tdata[gqad_pkg::HEAD_LSB +: gqad_pkg::HEAD_W];
        in_item.channel  = s_axis_tdata[gqad_pkg::CH_LSB +: gqad_pkg::CH_W];
        in_item.value    = s_axis_tdata[gqad_pkg::VAL_LSB +: gqad_pkg::VAL_W];
        // Group index by threshold compares, clamped to the last key/value head
        in_item.kv_head = '0;
        for (int i = 1; i < gqad_pkg::NUM_KV_HEADS; i++)
        begin
            if ({1'b0, in_item.head} >= (gqad_pkg::HEAD_W+1)'(i * gqad_pkg::Q_PER_KV))
            begin
                in_item.kv_head = gqad_pkg::KV_W'(i);
            end
        end
        unique case (in_item.kind)
            gqad_pkg::REQ_RUN:
                keep = {1'b0, in_item.head} < (gqad_pkg::HEAD_W+1)'(gqad_pkg::NUM_Q_HEADS);
            gqad_pkg::REQ_QUERY:
                keep = ({1'b0, in_item.head} < (gqad_pkg::HEAD_W+1)'(gqad_pkg::NUM_Q_HEADS))
                    && ({1'b0, in_item.channel} < (gqad_pkg::CH_W+1)'(gqad_pkg::HEAD_DIM));
            default:
                keep = ({1'b0, in_item.head} < (gqad_pkg::HEAD_W+1)'(gqad_pkg::NUM_KV_HEADS))
                    && ({1'b0, in_item.channel} < (gqad_pkg::CH_W+1)'(gqad_pkg::HEAD_DIM));
        endcase
    end

    assign s_axis_tready = (cnt_reg != (gqad_pkg::QPTR_W+1)'(gqad_pkg::QDEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign item_valid    = (cnt_reg != '0);
    assign item          = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !item_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && item_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Advance queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (item_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Hold queued requests
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* rtl/gqad_div.sv */
// Restoring divider, one quotient bit per cycle, for softmax normalization.
// Depends on gqad_pkg.
module gqad_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gqad_pkg::NUM_W-1:0]    num,
    input  logic [gqad_pkg::SUM_W-1:0]    den,
    output logic                          done,
    output logic [gqad_pkg::PROB_W-1:0]   quot
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [gqad_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [gqad_pkg::SUM_W-1:0]        rem_reg;
    logic [gqad_pkg::NUM_W-1:0]        quo_reg;
    logic [gqad_pkg::SUM_W-1:0]        den_reg;
    logic [gqad_pkg::SUM_W:0]          trial;
    logic [gqad_pkg::SUM_W:0]          diff;
    logic                              ge;

    // One shift-subtract step
    always_comb
    begin
        trial = {rem_reg, quo_reg[gqad_pkg::NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
    end

    assign done = done_reg;
    assign quot = quo_reg[gqad_pkg::PROB_W-1:0];

    // Sequence the iterations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= gqad_pkg::DIV_CNT_W'(gqad_pkg::NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[gqad_pkg::SUM_W-1:0] : trial[gqad_pkg::SUM_W-1:0];
            quo_reg <= {quo_reg[gqad_pkg::NUM_W-2:0], ge};
        end
    end

endmodule

/* rtl/gqad_engine.sv */
// Back end: cache and query memories, score/softmax/weighted-sum sequencer
// and output register. Depends on gqad_pkg, gqad_ram and gqad_div.
module gqad_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  gqad_pkg::item_t                    item,
    input  logic                               item_valid,
    output logic                               item_pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [gqad_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast
);

    gqad_pkg::eng_state_t                  state_reg, state_next;
    logic [gqad_pkg::HEAD_W-1:0]           qh_reg, qh_next;
    logic [gqad_pkg::KV_W-1:0]             kv_reg, kv_next;
    logic [gqad_pkg::SLOT_W-1:0]           last_idx_reg, last_idx_next;
    logic [gqad_pkg::SLOT_W-1:0]           begin_reg, begin_next;
    logic [gqad_pkg::SLOT_W-1:0]           idx_reg, idx_next;
    logic [gqad_pkg::CH_W-1:0]             ch_reg, ch_next;
    logic signed [gqad_pkg::SCORE_W-1:0]   top_reg, top_next;
    logic [gqad_pkg::SUM_W-1:0]            sum_reg, sum_next;
    logic signed [gqad_pkg::ACC_W-1:0]     acc_reg;
    logic                                  acc_clear;
    logic                                  rd_vld_reg;
    logic                                  prod_vld_reg;
    logic signed [gqad_pkg::PROD_W-1:0]    prod_reg;
    logic                                  mac_issue;
    logic                                  big_reg, big_next;
    logic [3:0]                            n_reg, n_next;
    logic [gqad_pkg::PROB_W-1:0]           fk_reg, fk_next;
    logic [gqad_pkg::LIN_W-1:0]            lin_reg, lin_next;
    logic [gqad_pkg::EXP_PROD_W-1:0]       prod2_reg, prod2_next;
    logic                                  out_vld_reg, out_vld_next;
    logic [gqad_pkg::CH_W-1:0]             out_ch_reg, out_ch_next;
    logic signed [gqad_pkg::VAL_W-1:0]     out_val_reg, out_val_next;
    logic                                  out_last_reg, out_last_next;

    // Memory ports
    logic                                  kc_we, vc_we, qs_we, ss_we;
    logic                                  kc_re, vc_re, qs_re, ss_re;
    logic [gqad_pkg::ROW_W+gqad_pkg::CH_W-1:0]   cache_waddr;
    logic [gqad_pkg::ROW_W+gqad_pkg::CH_W-1:0]   cache_raddr;
    logic [gqad_pkg::HEAD_W+gqad_pkg::CH_W-1:0]  qs_waddr;
    logic [gqad_pkg::HEAD_W+gqad_pkg::CH_W-1:0]  qs_raddr;
    logic [gqad_pkg::SCORE_W-1:0]          ss_wdata;
    logic [gqad_pkg::VAL_W-1:0]            kc_rdata, vc_rdata, qs_rdata;
    logic [gqad_pkg::SCORE_W-1:0]          ss_rdata;

    // Divider port
    logic                                  div_start;
    logic [gqad_pkg::NUM_W-1:0]            div_num;
    logic                                  div_done;
    logic [gqad_pkg::PROB_W-1:0]           div_quot;

    // Address and arithmetic helpers
    logic [gqad_pkg::SLOT_W:0]             slot_sum;
    logic [gqad_pkg::SLOT_W-1:0]           slot;
    logic [gqad_pkg::ROW_W-1:0]            rd_row;
    logic [gqad_pkg::ROW_W-1:0]            wr_row;
    logic [gqad_pkg::POS_W:0]              pos_p1;
    logic signed [gqad_pkg::MUL_A_W-1:0]   mul_a;
    logic signed [gqad_pkg::VAL_W-1:0]     mul_b;
    logic signed [gqad_pkg::ACC_W-1:0]     dot_adj;
    logic signed [gqad_pkg::ACC_W-1:0]     dot_q;
    logic signed [gqad_pkg::SCORE_W-1:0]   score_sat;
    logic signed [gqad_pkg::SCORE_W:0]     score_gap;
    logic [gqad_pkg::PROB_W-1:0]           fk1;
    logic [gqad_pkg::PROB_W-1:0]           fdiff;
    logic [gqad_pkg::PROB_W-1:0]           ef;
    logic [gqad_pkg::EXP_PROD_W-1:0]       wround;
    logic [gqad_pkg::PROB_W-1:0]           weight;
    logic signed [gqad_pkg::ACC_W-1:0]     out_round;
    logic signed [gqad_pkg::OUT_R_W-1:0]   out_r;
    logic signed [gqad_pkg::VAL_W-1:0]     out_sat;
    logic                                  out_free;

    assign slot_sum = {1'b0, begin_reg} + {1'b0, idx_reg};
    assign slot     = slot_sum[gqad_pkg::SLOT_W-1:0];
    assign rd_row   = gqad_pkg::ROW_W'(slot) * gqad_pkg::ROW_W'(gqad_pkg::NUM_KV_HEADS)
                    + gqad_pkg::ROW_W'(kv_reg);
    assign wr_row   = gqad_pkg::ROW_W'(item.position[gqad_pkg::SLOT_W-1:0])
                    * gqad_pkg::ROW_W'(gqad_pkg::NUM_KV_HEADS)
                    + gqad_pkg::ROW_W'(item.head);
    assign pos_p1   = {1'b0, item.position} + 1'b1;

    assign cache_waddr = {wr_row, item.channel};
    assign cache_raddr = {rd_row, ch_reg};
    assign qs_waddr    = {item.head, item.channel};
    assign qs_raddr    = {qh_reg, ch_reg};
    assign out_free    = !out_vld_reg || m_axis_tready;

    // Round a dot product toward zero on the divide by 8, then saturate
    always_comb
    begin
        dot_adj = acc_reg + (acc_reg[gqad_pkg::ACC_W-1] ? gqad_pkg::ACC_W'(7) : '0);
        dot_q   = dot_adj >>> 3;
        if (dot_q > gqad_pkg::ACC_W'(32'sh7FFF_FFFF))
        begin
            score_sat = 32'sh7FFF_FFFF;
        end
        else if (dot_q < -(gqad_pkg::ACC_W'(32'sh4000_0000) <<< 1))
        begin
            score_sat = 32'sh8000_0000;
        end
        else
        begin
            score_sat = dot_q[gqad_pkg::SCORE_W-1:0];
        end
    end

    // Exponential weight pieces
    always_comb
    begin
        score_gap = {top_reg[gqad_pkg::SCORE_W-1], top_reg}
                  - {ss_rdata[gqad_pkg::SCORE_W-1], ss_rdata};
        fk1    = gqad_pkg::frac_lut({1'b0, score_gap[15:12]} + 5'd1);
        fdiff  = gqad_pkg::frac_lut({1'b0, score_gap[15:12]}) - fk1;
        ef     = fk_reg - gqad_pkg::PROB_W'(lin_reg >> 12);
        wround = prod2_reg + gqad_pkg::EXP_PROD_W'(32768);
        weight = big_reg ? '0 : wround[16 +: gqad_pkg::PROB_W];
        div_num = {ss_rdata[gqad_pkg::PROB_W-1:0], 16'b0}
                + gqad_pkg::NUM_W'(sum_reg >> 1);
    end

    // Round the weighted value sum and saturate to the element range
    always_comb
    begin
        out_round = acc_reg + gqad_pkg::ACC_W'(32768);
        out_r     = out_round[gqad_pkg::ACC_W-1:16];
        if (out_r > gqad_pkg::OUT_R_W'(32767))
        begin
            out_sat = 16'sh7FFF;
        end
        else if (out_r < -gqad_pkg::OUT_R_W'(32768))
        begin
            out_sat = 16'sh8000;
        end
        else
        begin
            out_sat = out_r[gqad_pkg::VAL_W-1:0];
        end
    end

    // Shared multiplier operands: query*key while scoring, prob*value while summing
    always_comb
    begin
        if (state_reg == gqad_pkg::ST_AC_ISSUE || state_reg == gqad_pkg::ST_AC_DRAIN)
        begin
            mul_a = {1'b0, ss_rdata[gqad_pkg::PROB_W-1:0]};
            mul_b = vc_rdata;
        end
        else
        begin
            mul_a = {{(gqad_pkg::MUL_A_W-gqad_pkg::VAL_W){qs_rdata[gqad_pkg::VAL_W-1]}},
                     qs_rdata};
            mul_b = kc_rdata;
        end
    end

    // Next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        qh_next       = qh_reg;
        kv_next       = kv_reg;
        last_idx_next = last_idx_reg;
        begin_next    = begin_reg;
        idx_next      = idx_reg;
        ch_next       = ch_reg;
        top_next      = top_reg;
        sum_next      = sum_reg;
        big_next      = big_reg;
        n_next        = n_reg;
        fk_next       = fk_reg;
        lin_next      = lin_reg;
        prod2_next    = prod2_reg;
        out_vld_next  = out_vld_reg && !m_axis_tready;
        out_ch_next   = out_ch_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        item_pop      = 1'b0;
        kc_we         = 1'b0;
        vc_we         = 1'b0;
        qs_we         = 1'b0;
        ss_we         = 1'b0;
        kc_re         = 1'b0;
        vc_re         = 1'b0;
        qs_re         = 1'b0;
        ss_re         = 1'b0;
        ss_wdata      = '0;
        mac_issue     = 1'b0;
        acc_clear     = 1'b0;
        div_start     = 1'b0;
        unique case (state_reg)
            gqad_pkg::ST_IDLE:
            begin
                acc_clear = 1'b1;
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    unique case (item.kind)
                        gqad_pkg::REQ_KEY:   kc_we = 1'b1;
                        gqad_pkg::REQ_VALUE: vc_we = 1'b1;
                        gqad_pkg::REQ_QUERY: qs_we = 1'b1;
                        default:
                        begin
                            qh_next  = item.head;
                            kv_next  = item.kv_head;
                            idx_next = '0;
                            ch_next  = '0;
                            if (item.position >= gqad_pkg::POS_W'(gqad_pkg::CONTEXT_SLOTS - 1))
                            begin
                                last_idx_next = gqad_pkg::SLOT_W'(gqad_pkg::CONTEXT_SLOTS - 1);
                                begin_next    = pos_p1[gqad_pkg::SLOT_W-1:0];
                            end
                            else
                            begin
                                last_idx_next = item.position[gqad_pkg::SLOT_W-1:0];
                                begin_next    = '0;
                            end
                            state_next = gqad_pkg::ST_SC_ISSUE;
                        end
                    endcase
                end
            end
            gqad_pkg::ST_SC_ISSUE:
            begin
                kc_re     = 1'b1;
                qs_re     = 1'b1;
                mac_issue = 1'b1;
                ch_next   = ch_reg + 1'b1;
                if (ch_reg == gqad_pkg::LAST_CH)
                begin
                    ch_next    = '0;
                    state_next = gqad_pkg::ST_SC_DRAIN;
                end
            end
            gqad_pkg::ST_SC_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = gqad_pkg::ST_SC_DONE;
                end
            end
            gqad_pkg::ST_SC_DONE:
            begin
                ss_we     = 1'b1;
                ss_wdata  = score_sat;
                acc_clear = 1'b1;
                if (idx_reg == '0 || score_sat > top_reg)
                begin
                    top_next = score_sat;
                end
                if (idx_reg == last_idx_reg)
                begin
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = gqad_pkg::ST_WT_READ;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = gqad_pkg::ST_SC_ISSUE;
                end
            end
            gqad_pkg::ST_WT_READ:
            begin
                ss_re      = 1'b1;
                state_next = gqad_pkg::ST_WT_DATA;
            end
            gqad_pkg::ST_WT_DATA:
            begin
                big_next   = (score_gap[gqad_pkg::SCORE_W:20] != '0)
                          || (score_gap[19:16] >= 4'd12);
                n_next     = score_gap[19:16];
                fk_next    = gqad_pkg::frac_lut({1'b0, score_gap[15:12]});
                lin_next   = gqad_pkg::LIN_W'(fdiff[11:0]) * gqad_pkg::LIN_W'(score_gap[11:0]);
                state_next = gqad_pkg::ST_WT_MUL;
            end
            gqad_pkg::ST_WT_MUL:
            begin
                prod2_next = gqad_pkg::EXP_PROD_W'(gqad_pkg::intp_lut(n_reg))
                           * gqad_pkg::EXP_PROD_W'(ef);
                state_next = gqad_pkg::ST_WT_WRITE;
            end
            gqad_pkg::ST_WT_WRITE:
            begin
                ss_we    = 1'b1;
                ss_wdata = gqad_pkg::SCORE_W'(weight);
                sum_next = sum_reg + gqad_pkg::SUM_W'(weight);
                if (idx_reg == last_idx_reg)
                begin
                    idx_next   = '0;
                    state_next = gqad_pkg::ST_NM_READ;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = gqad_pkg::ST_WT_READ;
                end
            end
            gqad_pkg::ST_NM_READ:
            begin
                ss_re      = 1'b1;
                state_next = gqad_pkg::ST_NM_START;
            end
            gqad_pkg::ST_NM_START:
            begin
                div_start  = 1'b1;
                state_next = gqad_pkg::ST_NM_WAIT;
            end
            gqad_pkg::ST_NM_WAIT:
            begin
                if (div_done)
                begin
                    ss_we    = 1'b1;
                    ss_wdata = gqad_pkg::SCORE_W'(div_quot);
                    if (idx_reg == last_idx_reg)
                    begin
                        idx_next   = '0;
                        ch_next    = '0;
                        state_next = gqad_pkg::ST_AC_ISSUE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = gqad_pkg::ST_NM_READ;
                    end
                end
            end
            gqad_pkg::ST_AC_ISSUE:
            begin
                ss_re     = 1'b1;
                vc_re     = 1'b1;
                mac_issue = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == last_idx_reg)
                begin
                    idx_next   = '0;
                    state_next = gqad_pkg::ST_AC_DRAIN;
                end
            end
            gqad_pkg::ST_AC_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = gqad_pkg::ST_AC_EMIT;
                end
            end
            gqad_pkg::ST_AC_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_ch_next   = ch_reg;
                    out_val_next  = out_sat;
                    out_last_next = (ch_reg == gqad_pkg::LAST_CH);
                    acc_clear     = 1'b1;
                    if (ch_reg == gqad_pkg::LAST_CH)
                    begin
                        ch_next    = '0;
                        state_next = gqad_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = gqad_pkg::ST_AC_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = gqad_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gqad_pkg::ST_IDLE;
            out_vld_reg  <= 1'b0;
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_vld_reg  <= out_vld_next;
            rd_vld_reg   <= mac_issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        qh_reg       <= qh_next;
        kv_reg       <= kv_next;
        last_idx_reg <= last_idx_next;
        begin_reg    <= begin_next;
        idx_reg      <= idx_next;
        ch_reg       <= ch_next;
        top_reg      <= top_next;
        sum_reg      <= sum_next;
        big_reg      <= big_next;
        n_reg        <= n_next;
        fk_reg       <= fk_next;
        lin_reg      <= lin_next;
        prod2_reg    <= prod2_next;
        out_ch_reg   <= out_ch_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        prod_reg     <= mul_a * mul_b;
        if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + {{(gqad_pkg::ACC_W-gqad_pkg::PROD_W){prod_reg[gqad_pkg::PROD_W-1]}},
                                  prod_reg};
        end
        else if (acc_clear)
        begin
            acc_reg <= '0;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{gqad_pkg::OUT_PAD_W{1'b0}}, out_val_reg, out_ch_reg};
    assign m_axis_tlast  = out_last_reg;

    gqad_ram #(
        .WIDTH (gqad_pkg::VAL_W),
        .DEPTH (gqad_pkg::KC_DEPTH)
    ) u_key_cache (
        .clk   (clk),
        .we    (kc_we),
        .waddr (cache_waddr),
        .wdata (item.value),
        .re    (kc_re),
        .raddr (cache_raddr),
        .rdata (kc_rdata)
    );

    gqad_ram #(
        .WIDTH (gqad_pkg::VAL_W),
        .DEPTH (gqad_pkg::KC_DEPTH)
    ) u_value_cache (
        .clk   (clk),
        .we    (vc_we),
        .waddr (cache_waddr),
        .wdata (item.value),
        .re    (vc_re),
        .raddr (cache_raddr),
        .rdata (vc_rdata)
    );

    gqad_ram #(
        .WIDTH (gqad_pkg::VAL_W),
        .DEPTH (gqad_pkg::QS_DEPTH)
    ) u_query_store (
        .clk   (clk),
        .we    (qs_we),
        .waddr (qs_waddr),
        .wdata (item.value),
        .re    (qs_re),
        .raddr (qs_raddr),
        .rdata (qs_rdata)
    );

    gqad_ram #(
        .WIDTH (gqad_pkg::SCORE_W),
        .DEPTH (gqad_pkg::CONTEXT_SLOTS)
    ) u_score_store (
        .clk   (clk),
        .we    (ss_we),
        .waddr (slot),
        .wdata (ss_wdata),
        .re    (ss_re),
        .raddr (slot),
        .rdata (ss_rdata)
    );

    gqad_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (sum_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

endmodule

/* rtl/grouped_query_attention_decode.sv */
// Grouped-query attention decode for one token over a ring key/value cache
// of 1024 slots, 5 key/value heads shared by 15 query heads, 64 channels.
// Key, value and query load requests stream in at one per cycle while the queue
// has room; a run request for a query head scores it against the live slots
// (position+1, at most 1024), applies a fixed-point softmax and returns 64 Q7.8
// weighted value sums on the master stream, tlast on the final channel. Requests
// pass through a four-entry queue to a single sequencer, so loads behind a run
// wait until the run's last result has been handed to the output register. A run
// scores the live slots on one shared multiplier (one product per cycle), forms
// the exponential weights, normalizes each slot with a bit-serial 33-step divider
// and forms the weighted sums; output stalls can hold it back.
// Cache entries not yet written read back as unknown data.
// Depends on gqad_pkg, gqad_front, gqad_engine.
module grouped_query_attention_decode (
    input  logic                               clk,
    input  logic                               rst_n,
    // tdata: position[19:0], head[23:20], channel[29:24], elem_value[45:30], pad
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gqad_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [gqad_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    // tdata: out_channel[5:0], out_value[21:6], pad
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [gqad_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tlast
);

    gqad_pkg::item_t item;
    logic            item_valid;
    logic            item_pop;

    gqad_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop)
    );

    gqad_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/gqad_checker.sv */
// Port-level checks on the attention decode block, bound to its top level.
// Depends on gqad_pkg and grouped_query_attention_decode_macros.svh.
`include "grouped_query_attention_decode_macros.svh"

module gqad_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [gqad_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic                               m_axis_tlast
);

    // Ready toward the sender is a known level whenever the sender is valid
    `GQAD_ASSERT_SAME(a_in_ready_known, s_axis_tvalid, !$isunknown(s_axis_tready))

    // Hold a stalled result
    `GQAD_ASSERT_NEXT(a_out_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `GQAD_ASSERT_NEXT(a_out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // Last flag marks exactly the final channel of a head
    `GQAD_ASSERT_SAME(a_last_on_final_ch, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[gqad_pkg::CH_W-1:0] == gqad_pkg::LAST_CH))

    // Padding above the value stays clear
    `GQAD_ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[gqad_pkg::OUT_TDATA_W-1:gqad_pkg::CH_W+gqad_pkg::VAL_W] == '0)

endmodule

bind grouped_query_attention_decode gqad_checker u_gqad_checker (.*);

/* bench/testbench.sv */
// Self-checking bench for grouped_query_attention_decode: streams cache, query
// and run requests and checks every output element against a built-in predictor.
// Depends on gqad_pkg (request codes, stream widths) and the block's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIVE_SLOTS = 2;     // slots 0..1 of key/value head 0 are filled
    localparam int RUN_HEAD   = 0;     // the query head that is fully loaded and run
    localparam int RAND_ITEMS = 12;

    typedef struct {
        logic [5:0]         ch;
        logic signed [15:0] val;
        bit                 last;
    } out_elem_t;

    // Predicts the attention outputs and holds the ones not yet seen
    class attn_scoreboard;
        shortint   key_mem [gqad_pkg::KC_DEPTH];
        shortint   val_mem [gqad_pkg::KC_DEPTH];
        shortint   qry_mem [gqad_pkg::QS_DEPTH];
        longint    slot_score [gqad_pkg::CONTEXT_SLOTS];
        out_elem_t pending_outs [$];
        int        errors;
        int        seen;
        longint unsigned exp_int [12] = '{65536, 24109, 8869, 3263, 1200, 442,
                                          162, 60, 22, 8, 3, 1};
        longint unsigned exp_frac [17] = '{65536, 61565, 57835, 54331, 51039,
                                           47947, 45042, 42313, 39750, 37341,
                                           35079, 32954, 30957, 29081, 27319,
                                           25664, 24109};

        function longint unsigned exp_neg(longint unsigned d);
            longint unsigned n, f, k, r, ef;
            n = d >> 16;
            f = d & 64'hFFFF;
            k = f >> 12;
            r = f & 64'hFFF;
            if (n >= 12)
                return 0;
            ef = exp_frac[k] - (((exp_frac[k] - exp_frac[k+1]) * r) >> 12);
            return (exp_int[n] * ef + 32768) >> 16;
        endfunction

        function void predict_head(int unsigned pos, int unsigned qh);
            int unsigned     kv, live, first, s, base;
            longint          top, dot, rnd;
            longint unsigned sum;
            longint          acc [gqad_pkg::HEAD_DIM];
            out_elem_t       e;
            kv = qh / gqad_pkg::Q_PER_KV;
            if (kv >= gqad_pkg::NUM_KV_HEADS)
                kv = gqad_pkg::NUM_KV_HEADS - 1;
            live = (pos + 1 < gqad_pkg::CONTEXT_SLOTS) ? pos + 1 : gqad_pkg::CONTEXT_SLOTS;
            first = (pos + 1 - live) % gqad_pkg::CONTEXT_SLOTS;
            top = 64'sh8000_0000_0000_0000;
            sum = 0;
            // score every live slot, scaled down by 8
            for (int i = 0; i < live; i++)
            begin
                s = (first + i) % gqad_pkg::CONTEXT_SLOTS;
                base = (s * gqad_pkg::NUM_KV_HEADS + kv) * gqad_pkg::HEAD_DIM;
                dot = 0;
                for (int c = 0; c < gqad_pkg::HEAD_DIM; c++)
                    dot += longint'(qry_mem[qh*gqad_pkg::HEAD_DIM + c])
                         * longint'(key_mem[base + c]);
                dot = dot / 8;
                if (dot > 64'sd2147483647) dot = 64'sd2147483647;
                if (dot < -64'sd2147483648) dot = -64'sd2147483648;
                slot_score[s] = dot;
                if (dot > top) top = dot;
            end
            // exponential weights, then probabilities
            for (int i = 0; i < live; i++)
            begin
                s = (first + i) % gqad_pkg::CONTEXT_SLOTS;
                slot_score[s] = longint'(exp_neg(longint'(top - slot_score[s])));
                sum += slot_score[s];
            end
            for (int i = 0; i < live; i++)
            begin
                s = (first + i) % gqad_pkg::CONTEXT_SLOTS;
                slot_score[s] = longint'((longint'(slot_score[s]) * 65536 + sum / 2) / sum);
            end
            for (int c = 0; c < gqad_pkg::HEAD_DIM; c++)
                acc[c] = 0;
            for (int i = 0; i < live; i++)
            begin
                s = (first + i) % gqad_pkg::CONTEXT_SLOTS;
                base = (s * gqad_pkg::NUM_KV_HEADS + kv) * gqad_pkg::HEAD_DIM;
                for (int c = 0; c < gqad_pkg::HEAD_DIM; c++)
                    acc[c] += slot_score[s] * longint'(val_mem[base + c]);
            end
            // round, saturate and queue one element per channel
            for (int c = 0; c < gqad_pkg::HEAD_DIM; c++)
            begin
                rnd = (acc[c] + 32768) >>> 16;
                if (rnd > 32767) rnd = 32767;
                if (rnd < -32768) rnd = -32768;
                e.ch = c[5:0];
                e.val = rnd[15:0];
                e.last = (c == gqad_pkg::HEAD_DIM - 1);
                pending_outs.push_back(e);
            end
        endfunction

        function void note_request(gqad_pkg::req_t kind, int unsigned pos,
                                   int unsigned head, int unsigned ch, shortint val);
            int unsigned slot;
            slot = pos % gqad_pkg::CONTEXT_SLOTS;
            if (kind == gqad_pkg::REQ_RUN)
            begin
                if (head < gqad_pkg::NUM_Q_HEADS)
                    predict_head(pos, head);
            end
            else if (kind == gqad_pkg::REQ_QUERY)
            begin
                if (head < gqad_pkg::NUM_Q_HEADS)
                    qry_mem[head*gqad_pkg::HEAD_DIM + ch] = val;
            end
            else if (head < gqad_pkg::NUM_KV_HEADS)
            begin
                if (kind == gqad_pkg::REQ_KEY)
                    key_mem[(slot*gqad_pkg::NUM_KV_HEADS + head)*gqad_pkg::HEAD_DIM + ch] = val;
                else
                    val_mem[(slot*gqad_pkg::NUM_KV_HEADS + head)*gqad_pkg::HEAD_DIM + ch] = val;
            end
        endfunction

        function void check_result(logic [gqad_pkg::OUT_TDATA_W-1:0] data, logic last);
            out_elem_t e;
            seen++;
            if (pending_outs.size() == 0)
            begin
                $error("output element with nothing pending: tdata=%h", data);
                errors++;
                return;
            end
            e = pending_outs.pop_front();
            if (data[5:0] !== e.ch)
            begin
                $error("out_channel: expected %0d, got %0d", e.ch, data[5:0]);
                errors++;
            end
            if ($signed(data[21:6]) !== e.val)
            begin
                $error("out_value: expected %0d, got %0d", e.val, $signed(data[21:6]));
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [gqad_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic [gqad_pkg::IN_TUSER_W-1:0]  s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [gqad_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;

    attn_scoreboard sb;
    bit             hold_done;

    grouped_query_attention_decode dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly back to back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly small magnitudes so the softmax spreads, some full range
    function automatic shortint rand_elem();
        if ($urandom_range(0, 9) < 7)
            return shortint'($urandom_range(0, 600)) - 16'sd300;
        return shortint'($urandom);
    endfunction

    // Present one request from the next falling edge and hold until accepted
    task automatic send(gqad_pkg::req_t kind, int unsigned pos, int unsigned head,
                        int unsigned ch, shortint val);
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {2'b00, val, ch[5:0], head[3:0], pos[19:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_request(kind, pos, head, ch, val);
    endtask

    // Drop valid for a number of cycles after an accepted request
    task automatic idle_in(int n);
        if (n > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_gap(gqad_pkg::req_t kind, int unsigned pos, int unsigned head,
                            int unsigned ch, shortint val);
        send(kind, pos, head, ch, val);
        idle_in(gap_len());
    endtask

    // Receiver readiness, with one long hold-off once results are flowing
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sb.seen >= 100)
            begin
                hold_done = 1'b1;
                m_axis_tready = 1'b0;
                repeat (600) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            n = gap_len();
            if (n > 0)
            begin
                @(negedge clk);
                m_axis_tready = 1'b0;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    // Check every accepted output element
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int          k;
        int unsigned pos;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = gqad_pkg::REQ_KEY;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill the run head's query and the first slots of its key/value head
        for (int c = 0; c < gqad_pkg::HEAD_DIM; c++)
            send(gqad_pkg::REQ_QUERY, 0, RUN_HEAD, c, rand_elem());
        for (int s = 0; s < LIVE_SLOTS; s++)
            for (int c = 0; c < gqad_pkg::HEAD_DIM; c++)
            begin
                send(gqad_pkg::REQ_KEY, s, 0, c, rand_elem());
                send(gqad_pkg::REQ_VALUE, s + 1024 * $urandom_range(0, 1023), 0, c,
                     rand_elem());
            end
        idle_in(1);

        // Directed: extremes, ignored heads, single and full live sets
        send_gap(gqad_pkg::REQ_VALUE, 0, 0, 0, 16'sh7FFF);
        send_gap(gqad_pkg::REQ_VALUE, 20'hFFC00, 0, 63, -16'sh8000);
        send_gap(gqad_pkg::REQ_RUN, 0, RUN_HEAD, 0, 0);
        send_gap(gqad_pkg::REQ_RUN, 0, 15, 63, -1);
        send_gap(gqad_pkg::REQ_QUERY, 20'hFFFFF, RUN_HEAD, 63, 16'sh7FFF);
        send_gap(gqad_pkg::REQ_QUERY, 0, RUN_HEAD, 0, -16'sh8000);
        send_gap(gqad_pkg::REQ_KEY, 1, 0, 63, 16'sh7FFF);
        send_gap(gqad_pkg::REQ_KEY, 20'hFFFFF, 4, 63, -16'sh8000);
        send_gap(gqad_pkg::REQ_RUN, LIVE_SLOTS - 1, RUN_HEAD, 0, 0);
        send_gap(gqad_pkg::REQ_KEY, 3, 5, 10, 16'sh1234);
        send_gap(gqad_pkg::REQ_VALUE, 3, 15, 10, 16'sh1234);
        send_gap(gqad_pkg::REQ_QUERY, 3, 15, 10, 16'sh1234);
        send_gap(gqad_pkg::REQ_RUN, 1, 15, 0, 0);
        send_gap(gqad_pkg::REQ_RUN, 20'hFFC01 & 20'h00001, RUN_HEAD, 5, 16'sh0077);

        // Random loads and runs; runs stay inside the filled slots
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            k = $urandom_range(0, 9);
            if (k < 4)
                send_gap(gqad_pkg::REQ_RUN, $urandom_range(0, LIVE_SLOTS - 1),
                         ($urandom_range(0, 5) == 0) ? 15 : RUN_HEAD,
                         $urandom_range(0, 63), shortint'($urandom));
            else
            begin
                pos = $urandom_range(0, 20'hFFFFF);
                if ($urandom_range(0, 1))
                    pos = (pos & 20'hFFC00) | $urandom_range(0, LIVE_SLOTS - 1);
                send_gap(gqad_pkg::req_t'($urandom_range(0, 2)), pos, $urandom_range(0, 15),
                         $urandom_range(0, 63), rand_elem());
            end
        end
        idle_in(1);

        // Drain the remaining results, then allow a quiet tail
        while (sb.pending_outs.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/gqad_pkg.sv
rtl/gqad_ram.sv
rtl/gqad_front.sv
rtl/gqad_div.sv
rtl/gqad_engine.sv
rtl/grouped_query_attention_decode.sv
rtl/gqad_checker.sv
bench/testbench.sv
